@@ src/ppmg_pkg.sv @@
package ppmg_pkg;

  // Channel table depth
  localparam int MAX_CHANNELS = 16;

  // Field widths fixed by the stream format
  localparam int KIND_W  = 1;
  localparam int CH_W    = 4;
  localparam int WIDTH_W = 16;
  localparam int TICK_W  = 17;

  // Slot index runs from the start slot (0) up to MAX_CHANNELS
  localparam int IDX_W = $clog2(MAX_CHANNELS + 1);
  // Index into the channel tables
  localparam int CHI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Reset values
  localparam int DEFAULT_COUNT = 6;
  localparam int COUNT_RESET   = (DEFAULT_COUNT > MAX_CHANNELS) ? MAX_CHANNELS : DEFAULT_COUNT;
  localparam logic [WIDTH_W-1:0] SYNC_RESET = WIDTH_W'(350);
  localparam logic [WIDTH_W-1:0] GAP_RESET  = WIDTH_W'(300);
  localparam logic               IDLE_RESET = 1'b1;

  // Stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SLOT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP_LOW    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_LEVEL = 2'd2;

  // Item kinds on the input stream
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Classified commands
  typedef logic [1:0] ppmg_op_t;
  localparam ppmg_op_t OP_NOP        = 2'd0;
  localparam ppmg_op_t OP_STORE      = 2'd1;
  localparam ppmg_op_t OP_STORE_LAST = 2'd2;
  localparam ppmg_op_t OP_TICK       = 2'd3;

  typedef struct packed {
    ppmg_op_t            op;
    logic [CH_W-1:0]     channel;
    logic [WIDTH_W-1:0]  width;
  } ppmg_cmd_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] sync_slot;
    logic [WIDTH_W-1:0] gap_low;
    logic               idle_level;
  } ppmg_cfg_t;

  // Encoder state seen by the result stage
  typedef struct packed {
    logic               active;
    logic [IDX_W-1:0]   idx;
    logic [TICK_W-1:0]  tick;
  } ppmg_res_t;

endpackage

@@ src/ppmg_front.sv @@
module ppmg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic                in_last,
  input  logic [3:0]          in_channel,
  input  logic [15:0]         in_width,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output ppmg_pkg::ppmg_cmd_t cmd
);
  import ppmg_pkg::*;

  ppmg_cmd_t           q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  ppmg_cmd_t           cls;
  logic                push, pop;

  // Classify the incoming item
  always_comb begin
    cls.channel = in_channel;
    cls.width   = in_width;
    if (in_kind == KIND_TICK) begin
      cls.op = OP_TICK;
    end else if (int'(in_channel) < MAX_CHANNELS) begin
      cls.op = in_last ? OP_STORE_LAST : OP_STORE;
    end else begin
      cls.op = OP_NOP;  // write beyond the table: no effect
    end
  end

  // Queue handshake
  assign in_ready  = (cnt_r != QCNT_W'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ src/ppmg_back.sv @@
module ppmg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ppmg_pkg::ppmg_cmd_t cmd,
  input  ppmg_pkg::ppmg_cfg_t cfg,
  output logic                res_valid,
  input  logic                res_ready,
  output logic                res_level,
  output logic                res_busy
);
  import ppmg_pkg::*;

  typedef logic [MAX_CHANNELS-1:0][WIDTH_W-1:0] width_arr_t;

  width_arr_t          chan_r, chan_nxt;
  width_arr_t          frame_r, frame_nxt;
  logic [IDX_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic                active_r, active_nxt;
  ppmg_res_t           res_r;
  logic                res_valid_r;
  logic                go;
  logic [WIDTH_W-1:0]  cur_w, res_w, high_w;
  logic [IDX_W-1:0]    ch_count;
  logic [CHI_W-1:0]    ch_idx;

  // Width of a slot: start slot from the register, channels from the frame copy
  function automatic logic [WIDTH_W-1:0] slot_width(input logic [IDX_W-1:0]   idx,
                                                    input logic [WIDTH_W-1:0] sync,
                                                    input width_arr_t         frames);
    logic [IDX_W-1:0] k;
    k = idx - IDX_W'(1);
    if (idx == '0) begin
      return sync;
    end else if (int'(k) >= MAX_CHANNELS) begin
      return '0;
    end else begin
      return frames[CHI_W'(k)];
    end
  endfunction

  // Result register handshake
  assign cmd_ready = !res_valid_r | res_ready;
  assign go        = cmd_valid & cmd_ready;

  assign cur_w    = slot_width(idx_r, cfg.sync_slot, frame_r);
  assign ch_idx   = CHI_W'(cmd.channel);
  assign ch_count = IDX_W'(cmd.channel) + IDX_W'(1);

  // Command execution
  always_comb begin
    chan_nxt   = chan_r;
    frame_nxt  = frame_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    tick_nxt   = tick_r;
    active_nxt = active_r;
    if (go) begin
      unique case (cmd.op)
        OP_NOP: begin
        end
        OP_STORE: begin
          chan_nxt[ch_idx] = cmd.width;
        end
        OP_STORE_LAST: begin
          chan_nxt[ch_idx] = cmd.width;
          count_nxt        = ch_count;
          // Idle: latch the active channels and start a frame
          if (!active_r) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              if (i < int'(ch_count)) begin
                frame_nxt[i] = chan_nxt[i];
              end
            end
            idx_nxt    = '0;
            tick_nxt   = '0;
            active_nxt = 1'b1;
          end
        end
        OP_TICK: begin
          if (active_r) begin
            if (tick_r >= TICK_W'(cur_w)) begin
              tick_nxt = '0;
              if (idx_r >= count_r) begin
                idx_nxt    = '0;
                active_nxt = 1'b0;
              end else begin
                idx_nxt = idx_r + IDX_W'(1);
              end
            end else begin
              tick_nxt = tick_r + TICK_W'(1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= '0;
      frame_r     <= '0;
      count_r     <= IDX_W'(COUNT_RESET);
      idx_r       <= '0;
      tick_r      <= '0;
      active_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      chan_r   <= chan_nxt;
      frame_r  <= frame_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      tick_r   <= tick_nxt;
      active_r <= active_nxt;
      if (cmd_ready) begin
        res_valid_r <= cmd_valid;
      end
    end
  end

  // Snapshot of the state after the item
  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= '{active: active_nxt, idx: idx_nxt, tick: tick_nxt};
    end
  end

  // Pin level from the snapshot; frame copy is stable while a busy result waits
  assign res_w  = slot_width(res_r.idx, cfg.sync_slot, frame_r);
  assign high_w = (res_w > cfg.gap_low) ? (res_w - cfg.gap_low) : '0;

  assign res_valid = res_valid_r;
  assign res_busy  = res_r.active;
  assign res_level = res_r.active ? (res_r.tick < TICK_W'(high_w)) : cfg.idle_level;

endmodule

@@ src/ppm_pulse_train_generator.sv @@
// PPM pulse train generator: one result transfer per input transfer.
// Path from an input transfer to its output transfer: the command queue, then
// the execute stage into the result register.
// Throughput: one item per clock while the result stream is not stalled; the execute stage updates the encoder state.
// Reset (rst_n low, synchronous): queue and result emptied, encoder idle, channel and
// frame tables cleared, channel count 6, registers back to 350 / 300 / level high.
module ppm_pulse_train_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ppmg_pkg::IN_TDATA_W-1:0]       in_tdata,   // [3:0] channel, [19:4] width
  input  logic                                  in_tuser,   // [0] kind
  input  logic                                  in_tlast,
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ppmg_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [0] level, [1] busy_res
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [ppmg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [ppmg_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import ppmg_pkg::*;

  ppmg_cfg_t  cfg_r;
  ppmg_cmd_t  cmd;
  logic       cmd_valid, cmd_ready;
  logic       res_level, res_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_slot  <= SYNC_RESET;
      cfg_r.gap_low    <= GAP_RESET;
      cfg_r.idle_level <= IDLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SYNC_SLOT:  cfg_r.sync_slot  <= cfg_wdata[WIDTH_W-1:0];
        REG_GAP_LOW:    cfg_r.gap_low    <= cfg_wdata[WIDTH_W-1:0];
        REG_IDLE_LEVEL: cfg_r.idle_level <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Accept and classify
  ppmg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_last    (in_tlast),
    .in_channel (in_tdata[CH_W-1:0]),
    .in_width   (in_tdata[CH_W+WIDTH_W-1:CH_W]),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Encoder state and result register
  ppmg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_level (res_level),
    .res_busy  (res_busy)
  );

  assign out_tdata = {(OUT_TDATA_W - 2)'(0), res_busy, res_level};

  // Nothing is pending in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The queue only fills up while the result side is stalled
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // An idle result shows the idle level
  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> (out_tdata[0] == cfg_r.idle_level))
    else $error("idle result with wrong pin level");

endmodule

@@ verif/tb_ppm_pulse_train_generator.sv @@
`timescale 1ns / 1ps

module tb_ppm_pulse_train_generator;
  import ppmg_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_CAP      = 40;

  typedef struct {
    logic                kind;
    logic [CH_W-1:0]     ch;
    logic [WIDTH_W-1:0]  w;
    logic                last;
  } ppm_item_t;

  typedef struct {
    logic level;
    logic busy;
  } pin_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  ppm_pulse_train_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Encoder prediction state
  logic [WIDTH_W-1:0] chan_width [MAX_CHANNELS];
  logic [WIDTH_W-1:0] frame_width [MAX_CHANNELS];
  logic [4:0]         chan_count;
  logic [4:0]         slot_idx;
  logic [TICK_W-1:0]  slot_tick;
  logic               in_frame;
  logic [WIDTH_W-1:0] sync_ticks;
  logic [WIDTH_W-1:0] gap_ticks;
  logic               idle_pin;

  // Pin states still owed by the block, oldest first
  pin_t pending_pins [$];

  int mismatch_count;
  int items_sent, writes_sent, ticks_sent, frames_started, results_checked, reg_writes;
  int send_idle_pct, recv_stall_pct;
  int hold_request, hold_left;
  int quiet_cycles;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Width of the slot the encoder is in
  function automatic logic [WIDTH_W-1:0] cur_slot_len();
    if (slot_idx == 0) return sync_ticks;
    if (int'(slot_idx) - 1 >= MAX_CHANNELS) return '0;
    return frame_width[int'(slot_idx) - 1];
  endfunction

  function automatic void clear_encoder();
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      chan_width[i]  = '0;
      frame_width[i] = '0;
    end
    chan_count = 5'(COUNT_RESET);
    slot_idx   = '0;
    slot_tick  = '0;
    in_frame   = 1'b0;
    sync_ticks = SYNC_RESET;
    gap_ticks  = GAP_RESET;
    idle_pin   = IDLE_RESET;
  endfunction

  // Apply one item to the encoder state, return the pin state after it
  function automatic pin_t step_encoder(ppm_item_t it);
    pin_t               r;
    logic [WIDTH_W-1:0] len;
    logic [WIDTH_W-1:0] hi;
    if (it.kind == KIND_WRITE) begin
      chan_width[it.ch] = it.w;
      if (it.last) begin
        chan_count = 5'(it.ch) + 5'd1;
        if (!in_frame) begin
          for (int i = 0; i < MAX_CHANNELS; i++)
            if (i < chan_count) frame_width[i] = chan_width[i];
          slot_idx  = '0;
          slot_tick = '0;
          in_frame  = 1'b1;
          frames_started++;
        end
      end
    end else if (in_frame) begin
      if (slot_tick >= cur_slot_len()) begin
        slot_tick = '0;
        if (slot_idx >= chan_count) begin
          slot_idx = '0;
          in_frame = 1'b0;
        end else begin
          slot_idx = slot_idx + 5'd1;
        end
      end else begin
        slot_tick = slot_tick + 1'b1;
      end
    end
    len = cur_slot_len();
    hi  = (len > gap_ticks) ? len - gap_ticks : '0;
    r.level = in_frame ? (slot_tick < hi) : idle_pin;
    r.busy  = in_frame;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Offer one item; the prediction is made at the transfer
  task automatic send_item(input ppm_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tlast  <= it.last;
    in_tdata  <= IN_TDATA_W'({it.w, it.ch});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pins.push_back(step_encoder(it));
    items_sent++;
    if (it.kind == KIND_WRITE) writes_sent++;
    else ticks_sent++;
  endtask

  task automatic send_write(input int ch, input int w, input bit last);
    ppm_item_t it;
    it.kind = KIND_WRITE;
    it.ch   = CH_W'(ch);
    it.w    = WIDTH_W'(w);
    it.last = last;
    send_item(it);
  endtask

  // Ticks carry random payload bits, which the block ignores
  task automatic send_ticks(input int n);
    ppm_item_t it;
    for (int i = 0; i < n; i++) begin
      it.kind = KIND_TICK;
      it.ch   = CH_W'($urandom_range(15));
      it.w    = WIDTH_W'($urandom_range(65535));
      it.last = 1'($urandom_range(1));
      send_item(it);
    end
  endtask

  // Channels 0..top with small widths (0..10); last on top unless cut short
  task automatic send_burst(input int top, input bit broken);
    int stop_at;
    stop_at = broken ? $urandom_range(top) : top;
    for (int ch = 0; ch <= stop_at; ch++)
      send_write(ch, $urandom_range(10), !broken && ch == top);
  endtask

  // Sender goes quiet until every owed result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC_SLOT:  sync_ticks = val;
      REG_GAP_LOW:    gap_ticks  = val;
      REG_IDLE_LEVEL: idle_pin   = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_regs(input int sync_v, input int gap_v, input int idle_v);
    write_reg(REG_SYNC_SLOT, CFG_DATA_W'(sync_v));
    write_reg(REG_GAP_LOW, CFG_DATA_W'(gap_v));
    write_reg(REG_IDLE_LEVEL, CFG_DATA_W'(idle_v));
  endtask

  // Idle ticks right after reset see the reset idle level
  task automatic test_idle_after_reset();
    send_ticks(2);
    wait_for_results();
  endtask

  // Short slot, width extremes, count raised mid-frame
  task automatic test_basic_frame();
    set_regs(2, 1, 0);
    send_ticks(1);
    send_write(15, 16'hffff, 1'b0);
    send_write(0, 0, 1'b0);
    send_write(1, 1, 1'b0);
    send_write(2, 3, 1'b1);
    send_ticks(5);
    send_write(4, 2, 1'b1);
    send_ticks(12);
    wait_for_results();
  endtask

  // Register extremes, including live changes while a frame runs
  task automatic test_register_extremes();
    set_regs(16'hffff, 16'hffff, 1);
    send_ticks(1);
    send_write(0, 5, 1'b1);
    send_ticks(8);
    wait_for_results();
    set_regs(0, 0, 1);
    send_ticks(12);
    wait_for_results();
    write_reg(REG_SYNC_SLOT, 16'hffff);
    send_write(0, 2, 1'b1);
    send_ticks(6);
    wait_for_results();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure_fill();
    set_regs(3, 1, 0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_request = 300;
    send_burst(3, 1'b0);
    send_ticks(60);
    wait_for_results();
  endtask

  task automatic run_random_phase(input int snd_pct, input int rcv_pct, input int n_items);
    int start_count;
    int pick;
    int top;
    set_regs($urandom_range(8), $urandom_range(6), $urandom_range(1));
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      pick = $urandom_range(99);
      top  = ($urandom_range(7) == 0) ? $urandom_range(6, 15) : $urandom_range(4);
      if (!in_frame && pick < 45) begin
        send_burst(top, 1'b0);
      end else if (pick < 50) begin
        send_burst(top, 1'b1);
      end else if (pick < 55) begin
        send_write($urandom_range(15), $urandom_range(65535), 1'b0);
      end else if (pick < 60 && in_frame) begin
        // count change while a frame is running
        send_write($urandom_range(15), $urandom_range(10), 1'b1);
      end else begin
        send_ticks($urandom_range(1, 24));
      end
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 390);
    run_random_phase(58, 0, 390);
    run_random_phase(0, 58, 390);
    run_random_phase(20, 20, 390);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transfer against the oldest owed pin state
  always @(posedge clk) begin : check_results
    pin_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_pins.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing pending", out_tdata[1:0]));
      end else begin
        want = pending_pins.pop_front();
        if (out_tdata[0] !== want.level)
          report_mismatch($sformatf("level %b, predicted %b", out_tdata[0], want.level));
        if (out_tdata[1] !== want.busy)
          report_mismatch($sformatf("busy %b, predicted %b", out_tdata[1], want.busy));
      end
    end
  end

  // Watchdog on cycles with no transfer on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("ppm_pulse_train_generator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    clear_encoder();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_idle_after_reset();
    test_basic_frame();
    test_register_extremes();
    test_backpressure_fill();
    test_random_traffic();

    wait_for_results();
    repeat (6) @(posedge clk);
    if (pending_pins.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_pins.size()));
    $display("run: %0d items (%0d writes, %0d ticks), %0d frames, %0d register writes",
             items_sent, writes_sent, ticks_sent, frames_started, reg_writes);
    $display("run: %0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ppm_pulse_train_generator verification clean");
    end else begin
      $display("ppm_pulse_train_generator verification failed");
    end
    $finish;
  end

endmodule
